[rtl/spq_pkg.sv]
// shared types and constants for the sorted priority queue
`default_nettype none

package spq_pkg;

    localparam int CAPACITY_DEF = 16;
    localparam int VALUE_W      = 32;
    localparam int POS_W        = 8;
    localparam int COUNT_W      = 9;

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_FIND   = 2'd2;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_ABSENT = 2'd1;
    localparam logic [1:0] ST_FULL   = 2'd2;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_CMP,
        PH_UPD
    } t_phase;

    typedef struct packed {
        logic [1:0]                operation;
        logic signed [VALUE_W-1:0] value;
    } t_cmd;

    typedef struct packed {
        logic [1:0]                status;
        logic [POS_W-1:0]          position;
        logic signed [VALUE_W-1:0] head_value;
        logic [COUNT_W-1:0]        count;
    } t_result;

    // per-cycle control broadcast to every cell
    typedef struct packed {
        logic cmp;
        logic ins;
        logic rem;
    } t_cell_ctrl;

endpackage

`default_nettype wire

[rtl/spq_cell.sv]
// one storage cell of the sorted chain: holds an entry, compares it, shifts it
`default_nettype none

module spq_cell #(
    parameter int CAPACITY = spq_pkg::CAPACITY_DEF,
    parameter int IDX      = 0
) (
    input  wire logic                                i_clk,
    input  wire spq_pkg::t_cell_ctrl                 i_ctrl,
    input  wire logic signed [spq_pkg::VALUE_W-1:0]  i_key,
    input  wire logic [$clog2(CAPACITY+1)-1:0]       i_count,
    input  wire logic signed [spq_pkg::VALUE_W-1:0]  i_left_val,
    input  wire logic                                i_left_lt,
    input  wire logic signed [spq_pkg::VALUE_W-1:0]  i_right_val,
    output logic signed [spq_pkg::VALUE_W-1:0]       o_val,
    output logic                                     o_lt,
    output logic                                     o_eq,
    output logic signed [spq_pkg::VALUE_W-1:0]       o_next
);

    localparam int CW = $clog2(CAPACITY+1);
    localparam logic [CW-1:0] IDX_W = CW'(IDX);

    logic signed [spq_pkg::VALUE_W-1:0] r_val;
    logic signed [spq_pkg::VALUE_W-1:0] n_val;
    logic                               r_lt;
    logic                               r_eq;
    logic                               w_occ;

    assign w_occ = IDX_W < i_count;

    always_comb begin
        n_val = r_val;
        if (i_ctrl.ins) begin
            // smaller entries stay, the boundary cell takes the key, the rest move right
            if (!r_lt) begin
                n_val = i_left_lt ? i_key : i_left_val;
            end
        end else if (i_ctrl.rem) begin
            // when the key is present, entries from it onward move left
            if (!r_lt) begin
                n_val = i_right_val;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.cmp) begin
            r_lt <= w_occ && (r_val < i_key);
            r_eq <= w_occ && (r_val == i_key);
        end
        if (i_ctrl.ins || i_ctrl.rem) begin
            r_val <= n_val;
        end
    end

    assign o_val  = r_val;
    assign o_lt   = r_lt;
    assign o_eq   = r_eq;
    assign o_next = n_val;

endmodule

`default_nettype wire

[rtl/sorted_priority_queue_core.sv]
// top level of the sorted priority queue: command port, sequencer and cell chain
`default_nettype none

// Keeps up to CAPACITY signed 32-bit values in ascending order in a chain of
// cells, one entry per cell. A command is taken when start is high and busy is
// low; busy then stays high through a compare phase (every cell compares its
// entry with the key) and an update phase (every cell shifts or keeps its
// entry), so a new command can be taken only after both. The result appears
// on o_result with o_done high for exactly one cycle, in the cycle right after
// the update; there is no way to hold it off, so it must be captured then.
// Insert places the value ahead of equal entries, remove takes out the first
// equal entry, find reports its position; an insert into a full queue and a
// remove or find of an absent value leave the contents unchanged.
module sorted_priority_queue_core #(
    parameter int CAPACITY = spq_pkg::CAPACITY_DEF
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            start,
    input  wire spq_pkg::t_cmd   i_cmd,
    output logic                 busy,
    output logic                 o_done,
    output spq_pkg::t_result     o_result
);

    localparam int CW = $clog2(CAPACITY+1);
    localparam logic [CW-1:0] CAP_W = CW'(CAPACITY);

    spq_pkg::t_phase     r_phase;
    spq_pkg::t_phase     n_phase;
    spq_pkg::t_cmd       r_cmd;
    spq_pkg::t_cell_ctrl w_ctrl;
    spq_pkg::t_result    r_result;
    spq_pkg::t_result    n_result;
    logic [CW-1:0]       r_count;
    logic [CW-1:0]       n_count;
    logic                r_done;

    logic signed [spq_pkg::VALUE_W-1:0] w_val  [CAPACITY];
    logic signed [spq_pkg::VALUE_W-1:0] w_next [CAPACITY];
    logic [CAPACITY-1:0]                w_lt;
    logic [CAPACITY-1:0]                w_eq;
    logic [CAPACITY-1:0]                w_first;

    logic                        w_is_ins;
    logic                        w_is_rem;
    logic                        w_full;
    logic                        w_hit;
    logic [spq_pkg::POS_W-1:0]   w_pos;

    // command decode; the unused code behaves as find
    assign w_is_ins = r_cmd.operation == spq_pkg::OP_INSERT;
    assign w_is_rem = r_cmd.operation == spq_pkg::OP_REMOVE;
    assign w_full   = r_count == CAP_W;
    assign w_hit    = |w_eq;

    // first cell not below the key
    assign w_first = ~w_lt & {w_lt[CAPACITY-2:0], 1'b1};

    always_comb begin
        w_pos = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            if (w_first[i]) begin
                w_pos = w_pos | spq_pkg::POS_W'(i);
            end
        end
    end

    // next phase
    always_comb begin
        n_phase = r_phase;
        case (r_phase)
            spq_pkg::PH_IDLE: begin
                if (start) begin
                    n_phase = spq_pkg::PH_CMP;
                end
            end
            spq_pkg::PH_CMP: n_phase = spq_pkg::PH_UPD;
            spq_pkg::PH_UPD: n_phase = spq_pkg::PH_IDLE;
            default:         n_phase = spq_pkg::PH_IDLE;
        endcase
    end

    // phase outputs
    always_comb begin
        w_ctrl = '0;
        busy   = 1'b0;
        case (r_phase)
            spq_pkg::PH_IDLE: busy = 1'b0;
            spq_pkg::PH_CMP: begin
                busy       = 1'b1;
                w_ctrl.cmp = 1'b1;
            end
            spq_pkg::PH_UPD: begin
                busy       = 1'b1;
                w_ctrl.ins = w_is_ins && !w_full;
                w_ctrl.rem = w_is_rem && w_hit;
            end
            default: busy = 1'b0;
        endcase
    end

    always_comb begin
        n_count  = r_count;
        n_result = '0;
        if (w_is_ins) begin
            if (w_full) begin
                n_result.status = spq_pkg::ST_FULL;
            end else begin
                n_result.status   = spq_pkg::ST_OK;
                n_result.position = w_pos;
                n_count           = r_count + CW'(1);
            end
        end else if (w_hit) begin
            n_result.status   = spq_pkg::ST_OK;
            n_result.position = w_pos;
            if (w_is_rem) begin
                n_count = r_count - CW'(1);
            end
        end else begin
            n_result.status = spq_pkg::ST_ABSENT;
        end
        n_result.head_value = (n_count != '0) ? w_next[0] : '0;
        n_result.count      = spq_pkg::COUNT_W'(n_count);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= spq_pkg::PH_IDLE;
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_done  <= r_phase == spq_pkg::PH_UPD;
            if (r_phase == spq_pkg::PH_UPD) begin
                r_count <= n_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (start && !busy) begin
            r_cmd <= i_cmd;
        end
        if (r_phase == spq_pkg::PH_UPD) begin
            r_result <= n_result;
        end
    end

    assign o_done   = r_done;
    assign o_result = r_result;

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic signed [spq_pkg::VALUE_W-1:0] w_left_val;
        logic signed [spq_pkg::VALUE_W-1:0] w_right_val;
        logic                               w_left_lt;

        if (g == 0) begin : g_head
            assign w_left_val = r_cmd.value;
            assign w_left_lt  = 1'b1;
        end else begin : g_mid
            assign w_left_val = w_val[g-1];
            assign w_left_lt  = w_lt[g-1];
        end

        if (g == CAPACITY-1) begin : g_tail
            assign w_right_val = w_val[g];
        end else begin : g_inner
            assign w_right_val = w_val[g+1];
        end

        spq_cell #(
            .CAPACITY (CAPACITY),
            .IDX      (g)
        ) u_cell (
            .i_clk       (i_clk),
            .i_ctrl      (w_ctrl),
            .i_key       (r_cmd.value),
            .i_count     (r_count),
            .i_left_val  (w_left_val),
            .i_left_lt   (w_left_lt),
            .i_right_val (w_right_val),
            .o_val       (w_val[g]),
            .o_lt        (w_lt[g]),
            .o_eq        (w_eq[g]),
            .o_next      (w_next[g])
        );
    end

    a_done_after_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_phase == spq_pkg::PH_UPD))
        else $error("result strobe without an update cycle");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CAP_W)
        else $error("entry count beyond capacity");

    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("command transfer not followed by busy");

    a_full_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_result.status == spq_pkg::ST_FULL |-> r_count == CAP_W)
        else $error("full status while queue not full");

endmodule

`default_nettype wire

[verif/tb_top.sv]
// self-checking testbench for the sorted priority queue core
`timescale 1ns / 1ps

module tb_top;

    import spq_pkg::*;

    localparam int         CAP            = CAPACITY_DEF;
    localparam int         RANDOM_ITEMS   = 700;
    localparam int         WATCHDOG_LIMIT = 2000;
    localparam int         DRAIN_CYCLES   = 8;
    // code 3 is not defined and decodes as find
    localparam logic [1:0] OP_UNUSED      = 2'd3;

    localparam logic signed [VALUE_W-1:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [VALUE_W-1:0] VAL_MAX = 32'sh7fff_ffff;

    logic    i_clk   = 1'b0;
    logic    i_rst_n = 1'b0;
    logic    start   = 1'b0;
    t_cmd    cmd     = '0;
    logic    busy;
    logic    done;
    t_result result;

    // shadow copy of the queue contents, ascending
    logic signed [VALUE_W-1:0] shadow_vals [CAP];
    int                        shadow_len = 0;
    t_result                   pending_results [$];
    int                        mismatch_count  = 0;
    int                        idle_run        = 0;
    bit                        fill_mode       = 1'b1;

    sorted_priority_queue_core #(
        .CAPACITY (CAP)
    ) uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_cmd    (cmd),
        .busy     (busy),
        .o_done   (done),
        .o_result (result)
    );

    always #5 i_clk = ~i_clk;

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        $display("mismatch at %0t: %s", $time, msg);
    endtask

    // applies one command to the shadow queue and returns the result it must give
    function automatic t_result apply_queue_op(input t_cmd c);
        t_result r;
        int      pos;
        bit      hit;
        r   = '0;
        pos = 0;
        hit = 1'b0;
        if (c.operation == OP_INSERT) begin
            if (shadow_len >= CAP) begin
                r.status = ST_FULL;
            end else begin
                // new value goes ahead of any equal entries
                while (pos < shadow_len && $signed(shadow_vals[pos]) < $signed(c.value))
                    pos++;
                for (int i = shadow_len; i > pos; i--)
                    shadow_vals[i] = shadow_vals[i-1];
                shadow_vals[pos] = c.value;
                shadow_len++;
                r.status   = ST_OK;
                r.position = pos[POS_W-1:0];
            end
        end else begin
            while (!hit && pos < shadow_len) begin
                if (shadow_vals[pos] == c.value)
                    hit = 1'b1;
                else
                    pos++;
            end
            if (!hit) begin
                r.status = ST_ABSENT;
            end else begin
                r.status   = ST_OK;
                r.position = pos[POS_W-1:0];
                if (c.operation == OP_REMOVE) begin
                    for (int i = pos; i + 1 < shadow_len; i++)
                        shadow_vals[i] = shadow_vals[i+1];
                    shadow_len--;
                end
            end
        end
        r.head_value = (shadow_len > 0) ? shadow_vals[0] : '0;
        r.count      = shadow_len[COUNT_W-1:0];
        return r;
    endfunction

    // holds the command until the core takes it
    task automatic send_cmd(input logic [1:0] op, input logic signed [VALUE_W-1:0] val);
        t_cmd c;
        c.operation = op;
        c.value     = val;
        start <= 1'b1;
        cmd   <= c;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        pending_results.push_back(apply_queue_op(c));
    endtask

    task automatic idle_cycle();
        t_cmd junk;
        junk.operation = 2'($urandom_range(3));
        junk.value     = $urandom;
        start <= 1'b0;
        cmd   <= junk;
        @(posedge i_clk);
    endtask

    task automatic wait_drain();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic signed [VALUE_W-1:0] random_value();
        logic signed [VALUE_W-1:0] v;
        case ($urandom_range(3))
            0: v = $urandom_range(16) - 8;
            1: begin
                case ($urandom_range(3))
                    0: v = VAL_MIN;
                    1: v = VAL_MAX;
                    2: v = -1;
                    default: v = 0;
                endcase
            end
            default: v = $urandom;
        endcase
        return v;
    endfunction

    task automatic test_empty_queue();
        send_cmd(OP_FIND, 0);
        send_cmd(OP_REMOVE, 5);
        send_cmd(OP_UNUSED, VAL_MIN);
    endtask

    task automatic test_order_and_duplicates();
        send_cmd(OP_INSERT, VAL_MAX);
        send_cmd(OP_INSERT, VAL_MIN);
        send_cmd(OP_INSERT, 0);
        send_cmd(OP_INSERT, 0);
        send_cmd(OP_INSERT, -1);
        send_cmd(OP_FIND, 0);
        send_cmd(OP_UNUSED, VAL_MAX);
        send_cmd(OP_REMOVE, 0);
        send_cmd(OP_REMOVE, VAL_MIN);
        send_cmd(OP_REMOVE, 7);
        send_cmd(OP_REMOVE, 0);
        send_cmd(OP_REMOVE, -1);
        // last entry leaves, queue must read empty
        send_cmd(OP_REMOVE, VAL_MAX);
    endtask

    task automatic test_full_queue();
        send_cmd(OP_INSERT, VAL_MIN);
        // equal to the head, lands at position 0
        send_cmd(OP_INSERT, VAL_MIN);
        for (int i = 2; i < CAP; i++)
            send_cmd(OP_INSERT, random_value());
        send_cmd(OP_INSERT, VAL_MAX);
    endtask

    task automatic test_random_traffic(input int n_items, input int idle_pct);
        logic [1:0]                op;
        logic signed [VALUE_W-1:0] val;
        int                        roll;
        for (int k = 0; k < n_items; k++) begin
            while ($urandom_range(99) < idle_pct) idle_cycle();
            // swing between filling up and draining so both ends get visited
            if (shadow_len == CAP)
                fill_mode = 1'b0;
            else if (shadow_len == 0)
                fill_mode = 1'b1;
            roll = $urandom_range(99);
            if (roll < 4)
                op = OP_UNUSED;
            else if (roll < (fill_mode ? 64 : 28))
                op = OP_INSERT;
            else if (roll < 80)
                op = OP_REMOVE;
            else
                op = OP_FIND;
            if (op != OP_INSERT && shadow_len > 0 && $urandom_range(99) < 70)
                val = shadow_vals[$urandom_range(shadow_len - 1)];
            else
                val = random_value();
            send_cmd(op, val);
        end
    endtask

    // every result must match the oldest outstanding command
    always @(posedge i_clk) begin : result_check
        t_result want;
        if (i_rst_n && done) begin
            if (pending_results.size() == 0) begin
                report_mismatch("result with no command outstanding");
            end else begin
                want = pending_results.pop_front();
                if (result.status !== want.status)
                    report_mismatch($sformatf("status got %0d expected %0d",
                        result.status, want.status));
                if (result.position !== want.position)
                    report_mismatch($sformatf("position got %0d expected %0d",
                        result.position, want.position));
                if (result.head_value !== want.head_value)
                    report_mismatch($sformatf("head_value got %0d expected %0d",
                        $signed(result.head_value), $signed(want.head_value)));
                if (result.count !== want.count)
                    report_mismatch($sformatf("count got %0d expected %0d",
                        result.count, want.count));
            end
        end
    end

    // ends the run when no transfer happens for too long
    always @(posedge i_clk) begin
        if ((start && !busy) || done)
            idle_run <= 0;
        else
            idle_run <= idle_run + 1;
        if (idle_run >= WATCHDOG_LIMIT) begin
            $display("[sorted_priority_queue_core] ERROR");
            $finish;
        end
    end

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_queue();
        test_order_and_duplicates();
        test_full_queue();
        wait_drain();

        test_random_traffic(RANDOM_ITEMS / 3, 20);
        wait_drain();
        test_random_traffic(RANDOM_ITEMS / 3, 71);
        wait_drain();
        test_random_traffic(RANDOM_ITEMS - 2 * (RANDOM_ITEMS / 3), 0);

        wait_drain();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("[sorted_priority_queue_core] OK");
        else
            $display("[sorted_priority_queue_core] ERROR");
        $finish;
    end

endmodule

[sorted_priority_queue_core.f]
rtl/spq_pkg.sv
rtl/spq_cell.sv
rtl/sorted_priority_queue_core.sv
verif/tb_top.sv
